>>> rtl/cwc_pkg.sv
// Shared types, constants and register indexes for the critical window counter.
// Depends on nothing; every other file in rtl imports it.
package cwc_pkg;

  // Readings in one judged window (current word plus stored history).
  localparam int WINDOW_LENGTH = 5;
  localparam int HIST_LEN      = WINDOW_LENGTH - 1;

  localparam int READING_W = 16;
  localparam int COUNT_W   = 16;
  localparam int FILL_W    = $clog2(HIST_LEN + 1);
  localparam int HCNT_W    = $clog2(WINDOW_LENGTH + 1);
  localparam int HN_W      = (HCNT_W > 3) ? HCNT_W : 3;
  // Wide enough for the window sum and for floor times window length.
  localparam int SUM_W     = READING_W + $clog2(WINDOW_LENGTH);

  // With a zero floor the truncated average is >= 0 exactly when the
  // sum is above minus the window length.
  localparam logic signed [SUM_W-1:0] ZERO_FLOOR_THR = SUM_W'(1 - WINDOW_LENGTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [1:0] REG_HIGH_LEVEL    = 2'd0;
  localparam logic [1:0] REG_HIGH_NEEDED   = 2'd1;
  localparam logic [1:0] REG_CEILING       = 2'd2;
  localparam logic [1:0] REG_AVERAGE_FLOOR = 2'd3;

  typedef logic signed [READING_W-1:0] reading_t;
  typedef logic [WINDOW_LENGTH-1:0][READING_W-1:0] window_t;

  typedef struct packed {
    logic signed [15:0] high_level;
    logic [2:0]         high_needed;
    logic signed [15:0] ceiling;
    logic [14:0]        average_floor;
  } cfg_t;

  typedef struct packed {
    logic enough_highs;
    logic over_ceiling;
    logic average_ok;
  } verdict_t;

endpackage

>>> rtl/critical_window_counter.sv
// Top level of the critical window counter: input register, window history,
// judge and result register. Depends on cwc_pkg, cwc_cfg and cwc_judge.
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_ready  | in_reading, in_last_reading
//   out_     | output    | out_valid / out_ready| out_window_full, out_window_critical,
//            |           |                      | out_windows_so_far, out_sequence_end
//   cfg_     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One word per cycle sustained while out_ready holds; a word passes from the input
// register to the result register, with the judge between them.
// The window history and count update when a word moves into the result register.
// A stalled result holds the pipe; the input register still takes a word while
// the result waits, so in_ready drops only when both stages are full.
// Synchronous active-low reset empties the pipe, the window and the count.
module critical_window_counter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        in_reading,
  input  logic                      in_last_reading,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_window_full,
  output logic                      out_window_critical,
  output logic [15:0]               out_windows_so_far,
  output logic                      out_sequence_end,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);
  import cwc_pkg::*;

  cfg_t      cfg;
  verdict_t  verdict;
  window_t   win;

  logic                  s1_valid_r, s1_valid_nxt;
  reading_t              s1_reading_r;
  logic                  s1_last_r;
  logic                  s1_go;

  reading_t              hist_r [HIST_LEN];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt, count_upd;

  logic                  full;
  logic                  crit;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_full_r, out_crit_r, out_end_r;
  logic [COUNT_W-1:0]    out_count_r;

  cwc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Assemble the window: stored history, oldest first, then the current word.
  always_comb begin
    for (int i = 0; i < HIST_LEN; i++) begin
      win[i] = hist_r[i];
    end
    win[HIST_LEN] = s1_reading_r;
  end

  cwc_judge u_judge (
    .win     (win),
    .cfg     (cfg),
    .verdict (verdict)
  );

  assign full = (fill_r == FILL_W'(HIST_LEN));
  assign crit = full && verdict.enough_highs && !verdict.over_ceiling && verdict.average_ok;

  // Advance the input register when the result register is free or draining.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Saturating count of critical windows; clear on the last word.
  always_comb begin
    count_upd = count_r;
    if (crit && count_r != COUNT_MAX) count_upd = count_r + COUNT_W'(1);
    count_nxt = count_r;
    fill_nxt  = fill_r;
    if (s1_go) begin
      if (s1_last_r) begin
        count_nxt = '0;
        fill_nxt  = '0;
      end else begin
        count_nxt = count_upd;
        if (!full) fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
    end
  end

  // Capture the incoming word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_reading_r <= in_reading;
      s1_last_r    <= in_last_reading;
    end
  end

  // Shift the history; entries past the fill level are never judged.
  always_ff @(posedge clk) begin
    if (s1_go && !s1_last_r) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HIST_LEN-1] <= s1_reading_r;
    end
  end

  // Load the result register.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_full_r  <= full;
      out_crit_r  <= crit;
      out_count_r <= count_upd;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_window_full     = out_full_r;
  assign out_window_critical = out_crit_r;
  assign out_windows_so_far  = out_count_r;
  assign out_sequence_end    = out_end_r;

endmodule

>>> rtl/cwc_cfg.sv
// Configuration register bank for the critical window counter.
// Depends on cwc_pkg for the register indexes and the cfg_t bundle.
module cwc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output cwc_pkg::cfg_t       cfg
);
  import cwc_pkg::*;

  cfg_t cfg_r;

  // Capture writes by index; reset loads the documented defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_level    <= 16'sd70;
      cfg_r.high_needed   <= 3'd3;
      cfg_r.ceiling       <= 16'sd150;
      cfg_r.average_floor <= 15'd90;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_LEVEL:    cfg_r.high_level    <= cfg_data;
        REG_HIGH_NEEDED:   cfg_r.high_needed   <= cfg_data[2:0];
        REG_CEILING:       cfg_r.ceiling       <= cfg_data;
        REG_AVERAGE_FLOOR: cfg_r.average_floor <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/cwc_judge.sv
// Window evaluation: high-day count, ceiling check and average floor test.
// Depends on cwc_pkg for window_t, cfg_t and verdict_t.
module cwc_judge (
  input  cwc_pkg::window_t    win,
  input  cwc_pkg::cfg_t       cfg,
  output cwc_pkg::verdict_t   verdict
);
  import cwc_pkg::*;

  logic [HCNT_W-1:0]        highs;
  logic                     over;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  thr;
  reading_t                 r;

  // Parallel compares per reading and the window sum.
  always_comb begin
    highs = '0;
    over  = 1'b0;
    sum   = '0;
    r     = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      r = $signed(win[i]);
      if (r >= cfg.high_level) highs = highs + HCNT_W'(1);
      if (r > cfg.ceiling) over = 1'b1;
      sum = sum + {{(SUM_W-READING_W){r[READING_W-1]}}, r};
    end
  end

  // Truncated average >= floor, worked as a compare on the sum.
  always_comb begin
    if (cfg.average_floor == '0) begin
      thr = ZERO_FLOOR_THR;
    end else begin
      thr = $signed(SUM_W'(cfg.average_floor) * SUM_W'(WINDOW_LENGTH));
    end
  end

  assign verdict.enough_highs = HN_W'(highs) >= HN_W'(cfg.high_needed);
  assign verdict.over_ceiling = over;
  assign verdict.average_ok   = sum >= thr;

endmodule
